@@ src/two_pkg.sv @@
package two_pkg;

	// Field and register widths
	localparam int YAW_W  = 21;
	localparam int ANG_W  = 32;
	localparam int POS_W  = 40;
	localparam int CIRC_W = 18;
	localparam int OFS_W  = 18;
	localparam int DIST_W = 48;
	localparam int DTH_W  = YAW_W + 1;

	// Configuration port
	localparam int APB_DW = 32;
	localparam int ADDR_W = 4;
	localparam int IDX_W  = 2;
	localparam logic [IDX_W-1:0] REG_WHEEL_CIRC    = 2'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_OFFSET = 2'd1;
	localparam logic [IDX_W-1:0] REG_PERP_OFFSET   = 2'd2;
	localparam logic [CIRC_W-1:0] CIRC_RESET = 18'd56320;

	// Serial multiplier and divider
	localparam int MUL_AW = 48;
	localparam int MUL_BW = 32;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int DIV_NW = 50;
	localparam int DIV_DW = DTH_W;
	localparam int DIST_DIV = 36000;

	// Fixed-point scaling
	localparam int ANG_SHIFT = 13;
	localparam int G_SHIFT   = 10;
	localparam int FRAC_Q24  = 24;
	localparam int FRAC_Q30  = 30;
	localparam int COS_SHIFT = 6;
	localparam int KEEP_W    = 64;

	// CORDIC
	localparam int COR_AW = 38;
	localparam int COR_XW = 34;
	localparam int S_W    = COR_XW + 1;
	localparam int TABLE_LEN = 24;
	localparam int CORDIC_STEPS = 16;
	localparam int COR_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int COR_CW = $clog2(TABLE_LEN);
	localparam logic signed [COR_AW-1:0] COR_PI     = 38'sd3373259426;
	localparam logic signed [COR_AW-1:0] COR_TWO_PI = 38'sd6746518852;
	localparam logic signed [COR_AW-1:0] COR_HALF   = 38'sd1686629713;
	localparam logic signed [COR_AW-1:0] COR_NHALF  = -38'sd1686629713;
	localparam logic signed [COR_XW-1:0] COR_GAIN   = 34'sd652032874;

	// Status of a multi-cycle arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [2:0] {
		COR_IDLE,
		COR_RED,
		COR_FOLD,
		COR_ITER,
		COR_FIN
	} cor_st_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_DIV_P,
		ST_MUL_Q,
		ST_DIV_Q,
		ST_BRANCH,
		ST_COR_D,
		ST_DIV_G,
		ST_MUL_LX0,
		ST_MUL_LX1,
		ST_MUL_LY0,
		ST_MUL_LY1,
		ST_COR_M,
		ST_MUL_X0,
		ST_MUL_X1,
		ST_MUL_Y0,
		ST_MUL_Y1,
		ST_OUT
	} two_st_t;

	// Arctangent of 2^-i in Q30, truncated.
	function automatic logic [31:0] atan_q30(input logic [COR_CW-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			default: v = 32'h0000007F;
		endcase
		return v;
	endfunction

endpackage

@@ src/two_in_if.sv @@
interface two_in_if;
	logic valid;
	logic ready;
	logic signed [two_pkg::YAW_W-1:0] yaw_angle;
	logic signed [two_pkg::ANG_W-1:0] par_wheel_angle;
	logic signed [two_pkg::ANG_W-1:0] perp_wheel_angle;

	modport source (output valid, yaw_angle, par_wheel_angle, perp_wheel_angle, input ready);
	modport sink (input valid, yaw_angle, par_wheel_angle, perp_wheel_angle, output ready);
endinterface

@@ src/two_out_if.sv @@
interface two_out_if;
	logic valid;
	logic ready;
	logic signed [two_pkg::POS_W-1:0] pos_x;
	logic signed [two_pkg::POS_W-1:0] pos_y;
	logic signed [two_pkg::YAW_W-1:0] heading_out;

	modport source (output valid, pos_x, pos_y, heading_out, input ready);
	modport sink (input valid, pos_x, pos_y, heading_out, output ready);
endinterface

@@ src/two_mul.sv @@
module two_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [two_pkg::MUL_AW-1:0] a,
	input  logic signed [two_pkg::MUL_BW-1:0] b,
	output two_pkg::unit_stat_t stat,
	output logic signed [two_pkg::MUL_PW-1:0] prod
);
	import two_pkg::*;

	localparam int CW = $clog2(MUL_BW);

	logic signed [MUL_AW-1:0] a_q;
	logic signed [MUL_AW:0] hi_q;
	logic [MUL_BW-1:0] lo_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic signed [MUL_AW+1:0] a_ext;
	logic signed [MUL_AW+1:0] addend;
	logic signed [MUL_AW+1:0] sum;
	logic [MUL_AW+MUL_BW:0] full;

	// One multiplier bit per cycle, LSB first; the sign bit carries negative weight.
	always_comb begin
		a_ext = (MUL_AW+2)'(a_q);
		addend = '0;
		if (lo_q[0]) begin
			addend = (cnt_q == CW'(MUL_BW - 1)) ? -a_ext : a_ext;
		end
		sum = (MUL_AW+2)'(hi_q) + addend;
	end

	// Control state of the shift-add sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MUL_BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial product shifts right; low product bits replace the multiplier bits.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[MUL_AW+1:1];
			lo_q <= {sum[0], lo_q[MUL_BW-1:1]};
		end
	end

	assign full = {hi_q, lo_q};
	assign prod = full[MUL_PW-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

@@ src/two_div.sv @@
module two_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [two_pkg::DIV_NW-1:0] num,
	input  logic [two_pkg::DIV_DW-1:0] den,
	output two_pkg::unit_stat_t stat,
	output logic [two_pkg::DIV_NW-1:0] quo,
	output logic rem_nz
);
	import two_pkg::*;

	localparam int CW = $clog2(DIV_NW);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIV_DW:0] trial;
	logic [DIV_DW:0] diff;
	logic fits;

	// Restoring division, one quotient bit per cycle.
	always_comb begin
		trial = {rem_q, quo_q[DIV_NW-1]};
		diff = trial - {1'b0, den_q};
		fits = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign quo = quo_q;
	assign rem_nz = |rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

@@ src/two_cordic.sv @@
module two_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [two_pkg::COR_AW-1:0] angle,
	output two_pkg::unit_stat_t stat,
	output logic signed [two_pkg::COR_XW-1:0] sin_out,
	output logic signed [two_pkg::COR_XW-1:0] cos_out
);
	import two_pkg::*;

	cor_st_t state_q;
	cor_st_t state_d;
	logic signed [COR_AW-1:0] r_q;
	logic signed [COR_XW-1:0] x_q;
	logic signed [COR_XW-1:0] y_q;
	logic [COR_CW-1:0] i_q;
	logic neg_q;
	logic signed [COR_XW-1:0] xs;
	logic signed [COR_XW-1:0] ys;
	logic signed [COR_AW-1:0] at;
	logic in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= COR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Reduction into [-pi, pi), quadrant fold, then the rotation iterations.
	always_comb begin
		in_range = !r_q[COR_AW-1] && (r_q < COR_TWO_PI);
		state_d = state_q;
		case (state_q)
			COR_IDLE: if (start) state_d = COR_RED;
			COR_RED: if (in_range) state_d = COR_FOLD;
			COR_FOLD: state_d = COR_ITER;
			COR_ITER: if (i_q == COR_CW'(COR_ITERS - 1)) state_d = COR_FIN;
			COR_FIN: state_d = COR_IDLE;
			default: state_d = COR_IDLE;
		endcase
	end

	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = {{(COR_AW-32){1'b0}}, atan_q30(i_q)};
	end

	always_ff @(posedge clk) begin
		case (state_q)
			COR_IDLE: begin
				if (start) begin
					r_q <= angle + COR_PI;
				end
			end
			COR_RED: begin
				if (r_q[COR_AW-1]) begin
					r_q <= r_q + COR_TWO_PI;
				end else if (!in_range) begin
					r_q <= r_q - COR_TWO_PI;
				end else begin
					r_q <= r_q - COR_PI;
				end
			end
			COR_FOLD: begin
				x_q <= COR_GAIN;
				y_q <= '0;
				i_q <= '0;
				if (r_q > COR_HALF) begin
					r_q <= r_q - COR_PI;
					neg_q <= 1'b1;
				end else if (r_q < COR_NHALF) begin
					r_q <= r_q + COR_PI;
					neg_q <= 1'b1;
				end else begin
					neg_q <= 1'b0;
				end
			end
			COR_ITER: begin
				i_q <= i_q + 1'b1;
				if (!r_q[COR_AW-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					r_q <= r_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					r_q <= r_q + at;
				end
			end
			default: begin
			end
		endcase
	end

	assign sin_out = neg_q ? -y_q : y_q;
	assign cos_out = neg_q ? -x_q : x_q;
	assign stat.busy = (state_q != COR_IDLE);
	assign stat.done = (state_q == COR_FIN);
endmodule

@@ src/tracking_wheel_odometry_unit.sv @@
// Tracking-wheel arc odometry: one pose update for each input beat.
// The input channel carries the IMU yaw and the cumulative angles of the
// parallel and perpendicular tracking wheels; the output channel carries the
// global x/y position and the stored heading. Both use valid/ready, and a
// beat moves at a clock edge where both are high.
// The APB port holds the wheel circumference and the two wheel offsets.
// An item passes from acceptance to the result beat through a shift-add
// multiplier retiring one multiplier bit per cycle (up to ten products), a
// restoring divider retiring one quotient bit per cycle (up to three
// quotients) and an iterative CORDIC (twice). Without a perpendicular
// wheel and with no heading change, five products, one quotient and one
// CORDIC run remain. One item is processed at a time; the next is accepted
// as soon as the result sits in the output register, even if the receiver
// has not taken it.
// A stalled receiver holds the result; a finished item then waits for the
// output register to free up before the next input is accepted.
// Reset clears the pose, the stored distances and heading, and restores the
// register defaults.
module tracking_wheel_odometry_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [two_pkg::ADDR_W-1:0] paddr,
	input  logic [two_pkg::APB_DW-1:0] pwdata,
	output logic [two_pkg::APB_DW-1:0] prdata,
	output logic pready,
	two_in_if.sink in_ch,
	two_out_if.source out_ch
);
	import two_pkg::*;

	two_st_t state_q;
	two_st_t state_d;

	// Configuration
	logic [CIRC_W-1:0] circ_q;
	logic signed [OFS_W-1:0] center_q;
	logic signed [OFS_W-1:0] perp_ofs_q;
	logic [IDX_W-1:0] reg_idx;
	logic cfg_wr;

	// Pose state
	logic signed [DIST_W-1:0] last_par_q;
	logic signed [DIST_W-1:0] last_perp_q;
	logic signed [YAW_W-1:0] last_head_q;
	logic [POS_W-1:0] acc_x_q;
	logic [POS_W-1:0] acc_y_q;

	// Working registers
	logic signed [ANG_W-1:0] par_q;
	logic signed [ANG_W-1:0] perp_q;
	logic signed [DTH_W-1:0] dth_q;
	logic signed [DTH_W-1:0] mid_q;
	logic signed [DIST_W-1:0] dpar_q;
	logic signed [DIST_W-1:0] dperp_q;
	logic signed [S_W-1:0] s_q;
	logic signed [MUL_BW-1:0] g_q;
	logic signed [DIST_W-1:0] lx_q;
	logic signed [DIST_W-1:0] ly_q;
	logic signed [MUL_BW-1:0] c24_q;
	logic signed [MUL_BW-1:0] s24_q;
	logic [KEEP_W-1:0] t_q;
	logic div_neg_q;
	logic launched_q;

	// Output register
	logic out_valid_q;
	logic signed [POS_W-1:0] out_x_q;
	logic signed [POS_W-1:0] out_y_q;
	logic signed [YAW_W-1:0] out_h_q;

	// Unit connections
	logic mul_go;
	logic div_go;
	logic cor_go;
	unit_stat_t mul_stat;
	unit_stat_t div_stat;
	unit_stat_t cor_stat;
	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic signed [MUL_PW-1:0] mul_prod;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic [DIV_NW-1:0] div_quo;
	logic div_rem_nz;
	logic div_neg;
	logic signed [COR_AW-1:0] cor_angle;
	logic signed [COR_XW-1:0] cor_sin;
	logic signed [COR_XW-1:0] cor_cos;

	// Control decode
	logic is_mul;
	logic is_div;
	logic is_cor;
	logic unit_done;
	logic in_ready;
	logic out_load;

	// Derived values
	logic signed [MUL_PW-1:0] p24;
	logic signed [MUL_PW-1:0] p30;
	logic [MUL_PW-1:0] abs_prod;
	logic [S_W-1:0] abs_s;
	logic [DTH_W-1:0] abs_dth;
	logic [DIST_W-1:0] dist_mag;
	logic [DIST_W-1:0] dist_val;
	logic [MUL_BW-1:0] g_mag;
	logic [KEEP_W-1:0] sum_x;
	logic [KEEP_W-1:0] sum_y;
	logic signed [COR_XW-1:0] cos_sh;
	logic signed [COR_XW-1:0] sin_sh;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q <= CIRC_RESET;
			center_q <= '0;
			perp_ofs_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WHEEL_CIRC: circ_q <= pwdata[CIRC_W-1:0];
				REG_CENTER_OFFSET: center_q <= pwdata[OFS_W-1:0];
				REG_PERP_OFFSET: perp_ofs_q <= pwdata[OFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WHEEL_CIRC: prdata = {{(APB_DW-CIRC_W){1'b0}}, circ_q};
			REG_CENTER_OFFSET: prdata = APB_DW'(center_q);
			REG_PERP_OFFSET: prdata = APB_DW'(perp_ofs_q);
			default: prdata = '0;
		endcase
	end

	// Arithmetic units
	two_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_go),
		.a(mul_a),
		.b(mul_b),
		.stat(mul_stat),
		.prod(mul_prod)
	);

	two_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_go),
		.num(div_num),
		.den(div_den),
		.stat(div_stat),
		.quo(div_quo),
		.rem_nz(div_rem_nz)
	);

	two_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cor_go),
		.angle(cor_angle),
		.stat(cor_stat),
		.sin_out(cor_sin),
		.cos_out(cor_cos)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			launched_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (unit_done) begin
				launched_q <= 1'b0;
			end else if (mul_go || div_go || cor_go) begin
				launched_q <= 1'b1;
			end
		end
	end

	// Next state, unit launches and handshakes
	always_comb begin
		is_mul = state_q inside {ST_MUL_P, ST_MUL_Q, ST_MUL_LX0, ST_MUL_LX1, ST_MUL_LY0,
			ST_MUL_LY1, ST_MUL_X0, ST_MUL_X1, ST_MUL_Y0, ST_MUL_Y1};
		is_div = state_q inside {ST_DIV_P, ST_DIV_Q, ST_DIV_G};
		is_cor = state_q inside {ST_COR_D, ST_COR_M};
		mul_go = is_mul && !launched_q && !mul_stat.busy;
		div_go = is_div && !launched_q && !div_stat.busy;
		cor_go = is_cor && !launched_q && !cor_stat.busy;
		unit_done = launched_q && ((is_mul && mul_stat.done) || (is_div && div_stat.done)
			|| (is_cor && cor_stat.done));
		in_ready = 1'b0;
		out_load = 1'b0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_ch.valid) state_d = ST_MUL_P;
			end
			ST_MUL_P: if (unit_done) state_d = ST_DIV_P;
			ST_DIV_P: begin
				if (unit_done) state_d = (perp_ofs_q != '0) ? ST_MUL_Q : ST_BRANCH;
			end
			ST_MUL_Q: if (unit_done) state_d = ST_DIV_Q;
			ST_DIV_Q: if (unit_done) state_d = ST_BRANCH;
			ST_BRANCH: state_d = (dth_q != '0) ? ST_COR_D : ST_COR_M;
			ST_COR_D: if (unit_done) state_d = ST_DIV_G;
			ST_DIV_G: if (unit_done) state_d = ST_MUL_LX0;
			ST_MUL_LX0: if (unit_done) state_d = ST_MUL_LX1;
			ST_MUL_LX1: if (unit_done) state_d = ST_MUL_LY0;
			ST_MUL_LY0: if (unit_done) state_d = ST_MUL_LY1;
			ST_MUL_LY1: if (unit_done) state_d = ST_COR_M;
			ST_COR_M: if (unit_done) state_d = ST_MUL_X0;
			ST_MUL_X0: if (unit_done) state_d = ST_MUL_X1;
			ST_MUL_X1: if (unit_done) state_d = ST_MUL_Y0;
			ST_MUL_Y0: if (unit_done) state_d = ST_MUL_Y1;
			ST_MUL_Y1: if (unit_done) state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Operand selection for the multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_P: begin
				mul_a = MUL_AW'(par_q);
				mul_b = {{(MUL_BW-CIRC_W){1'b0}}, circ_q};
			end
			ST_MUL_Q: begin
				mul_a = MUL_AW'(perp_q);
				mul_b = {{(MUL_BW-CIRC_W){1'b0}}, circ_q};
			end
			ST_MUL_LX0: begin
				mul_a = dpar_q;
				mul_b = g_q;
			end
			ST_MUL_LX1: begin
				mul_a = MUL_AW'(s_q);
				mul_b = MUL_BW'(center_q);
			end
			ST_MUL_LY0: begin
				mul_a = dperp_q;
				mul_b = g_q;
			end
			ST_MUL_LY1: begin
				mul_a = MUL_AW'(s_q);
				mul_b = MUL_BW'(perp_ofs_q);
			end
			ST_MUL_X0: begin
				mul_a = lx_q;
				mul_b = c24_q;
			end
			ST_MUL_X1: begin
				mul_a = ly_q;
				mul_b = s24_q;
			end
			ST_MUL_Y0: begin
				mul_a = lx_q;
				mul_b = s24_q;
			end
			ST_MUL_Y1: begin
				mul_a = ly_q;
				mul_b = c24_q;
			end
			default: begin
			end
		endcase
	end

	// Divider operands: magnitudes, with the quotient sign kept aside
	always_comb begin
		abs_prod = mul_prod[MUL_PW-1] ? -mul_prod : mul_prod;
		abs_s = s_q[S_W-1] ? -s_q : s_q;
		abs_dth = dth_q[DTH_W-1] ? -dth_q : dth_q;
		if (state_q == ST_DIV_G) begin
			div_num = DIV_NW'({abs_s, {G_SHIFT{1'b0}}});
			div_den = abs_dth;
			div_neg = s_q[S_W-1] ^ dth_q[DTH_W-1];
		end else begin
			div_num = abs_prod[DIV_NW-1:0];
			div_den = DIV_DW'(DIST_DIV);
			div_neg = mul_prod[MUL_PW-1];
		end
	end

	// Rotation angle in Q30: half the heading change, or the mid-step heading
	assign cor_angle = ((state_q == ST_COR_D) ? COR_AW'(dth_q) : COR_AW'(mid_q)) <<< ANG_SHIFT;

	// Result shaping
	always_comb begin
		p24 = mul_prod >>> FRAC_Q24;
		p30 = mul_prod >>> FRAC_Q30;
		dist_mag = div_quo[DIST_W-1:0];
		dist_val = div_neg_q ? (-dist_mag - DIST_W'(div_rem_nz)) : dist_mag;
		g_mag = div_quo[MUL_BW-1:0];
		sum_x = t_q - mul_prod[KEEP_W-1:0];
		sum_y = t_q + mul_prod[KEEP_W-1:0];
		cos_sh = cor_cos >>> COS_SHIFT;
		sin_sh = cor_sin >>> COS_SHIFT;
	end

	// Pose state: stored distances, heading and accumulated position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_par_q <= '0;
			last_perp_q <= '0;
			last_head_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else begin
			if (in_ready && in_ch.valid) begin
				last_head_q <= in_ch.yaw_angle;
			end
			if (unit_done) begin
				case (state_q)
					ST_DIV_P: begin
						last_par_q <= dist_val;
						if (perp_ofs_q == '0) last_perp_q <= '0;
					end
					ST_DIV_Q: last_perp_q <= dist_val;
					ST_MUL_X1: acc_x_q <= acc_x_q + sum_x[KEEP_W-1:FRAC_Q24];
					ST_MUL_Y1: acc_y_q <= acc_y_q + sum_y[KEEP_W-1:FRAC_Q24];
					default: begin
					end
				endcase
			end
		end
	end

	// Working registers, captured on input acceptance, at the branch and as each unit finishes
	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid) begin
			par_q <= in_ch.par_wheel_angle;
			perp_q <= in_ch.perp_wheel_angle;
			dth_q <= DTH_W'(in_ch.yaw_angle) - DTH_W'(last_head_q);
			mid_q <= DTH_W'(in_ch.yaw_angle) + DTH_W'(last_head_q);
		end
		if (div_go) begin
			div_neg_q <= div_neg;
		end
		if (state_q == ST_BRANCH && dth_q == '0) begin
			lx_q <= dpar_q;
			ly_q <= dperp_q;
		end
		if (unit_done) begin
			case (state_q)
				ST_DIV_P: begin
					dpar_q <= dist_val - last_par_q;
					if (perp_ofs_q == '0) dperp_q <= -last_perp_q;
				end
				ST_DIV_Q: dperp_q <= dist_val - last_perp_q;
				ST_COR_D: s_q <= {cor_sin, 1'b0};
				ST_DIV_G: g_q <= div_neg_q ? -g_mag : g_mag;
				ST_MUL_LX0: lx_q <= p24[DIST_W-1:0];
				ST_MUL_LX1: lx_q <= lx_q - p30[DIST_W-1:0];
				ST_MUL_LY0: ly_q <= p24[DIST_W-1:0];
				ST_MUL_LY1: ly_q <= ly_q + p30[DIST_W-1:0];
				ST_COR_M: begin
					c24_q <= MUL_BW'(cos_sh);
					s24_q <= MUL_BW'(sin_sh);
				end
				ST_MUL_X0: t_q <= mul_prod[KEEP_W-1:0];
				ST_MUL_Y0: t_q <= mul_prod[KEEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Output register: holds the beat while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q <= acc_x_q;
			out_y_q <= acc_y_q;
			out_h_q <= last_head_q;
		end
	end

	assign in_ch.ready = in_ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.pos_x = out_x_q;
	assign out_ch.pos_y = out_y_q;
	assign out_ch.heading_out = out_h_q;
endmodule
